FILE: rtl/core/cpv_pkg.sv
// Shared types, constants and lookup tables for the camera pose / view matrix block.
// No dependencies; imported by every module under rtl/core.
package cpv_pkg;

  localparam int unsigned SINE_TABLE_BITS = 10;
  localparam int unsigned SC_RBITS        = SINE_TABLE_BITS - 2;
  localparam int unsigned SC_QUARTER      = 2 ** SC_RBITS;

  localparam logic [15:0]        PI_Q13     = 16'd25736;
  localparam logic [16:0]        TWO_PI_Q13 = 17'd51472;
  localparam logic signed [15:0] PITCH_MAX  = 16'sd12288;
  localparam logic signed [15:0] DIR_ONE    = 16'sd16384;

  localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // multiply-accumulate widths: 16x32 products, three terms, Q14 rounding
  localparam int unsigned PROD_W = 48;
  localparam int unsigned ACC_W  = 49;
  localparam int unsigned RES_W  = ACC_W - 14;

  typedef logic signed [15:0] dir_t;
  typedef logic signed [31:0] pos_t;
  typedef logic signed [RES_W-1:0] res_t;
  typedef logic signed [RES_W:0]   wres_t;

  typedef enum logic [2:0] {
    REQ_YAW   = 3'd0,
    REQ_PITCH = 3'd1,
    REQ_FWD   = 3'd2,
    REQ_RIGHT = 3'd3,
    REQ_UP    = 3'd4,
    REQ_RESET = 3'd5
  } req_type_e;

  localparam logic [1:0] CFG_START_X = 2'd0;
  localparam logic [1:0] CFG_START_Y = 2'd1;
  localparam logic [1:0] CFG_START_Z = 2'd2;

  localparam logic [1:0] ROW_RIGHT = 2'd0;
  localparam logic [1:0] ROW_UP    = 2'd1;
  localparam logic [1:0] ROW_FWD   = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ANGLE,
    ST_SCP_GO,
    ST_SCP_WAIT,
    ST_SCY_GO,
    ST_SCY_WAIT,
    ST_FRAME,
    ST_MAC_GO,
    ST_MAC_WAIT,
    ST_PUSH
  } cpv_state_e;

  typedef enum logic [3:0] {
    JOB_FWD_X,
    JOB_FWD_Z,
    JOB_UP_X,
    JOB_UP_Y,
    JOB_UP_Z,
    JOB_MOVE_X,
    JOB_MOVE_Y,
    JOB_MOVE_Z,
    JOB_DOT_R,
    JOB_DOT_U,
    JOB_DOT_F
  } cpv_job_e;

  typedef enum logic [1:0] {
    SC_IDLE,
    SC_MUL,
    SC_LOOK
  } sc_state_e;

  typedef struct packed {
    logic              start;
    logic signed [15:0] angle;
  } sc_req_t;

  typedef struct packed {
    logic done;
    dir_t sin;
    dir_t cos;
  } sc_rsp_t;

  typedef struct packed {
    logic       start;
    logic [1:0] nterms;
    dir_t       a;
    pos_t       b;
    logic       neg;
  } mac_req_t;

  typedef struct packed {
    logic       done;
    logic [1:0] term;
    res_t       result;
  } mac_rsp_t;

  typedef logic [15:0] lut_t [SC_QUARTER];

  function automatic logic [63:0] one_minus(input logic [63:0] sub);
    return (sub > Q30_ONE) ? 64'd0 : Q30_ONE - sub;
  endfunction

  // first quadrant sine or cosine, Q1.14, from a Taylor series in Q30
  function automatic lut_t build_lut(input logic want_cos);
    lut_t        lut;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] v;
    for (int unsigned r = 0; r < SC_QUARTER; r++) begin
      x  = (64'(r) * HALF_PI_Q30) >> SC_RBITS;
      x2 = (x * x) >> 30;
      t  = Q30_ONE;
      if (!want_cos) begin
        t = one_minus(((x2 * t) >> 30) / 64'd110);
        t = one_minus(((x2 * t) >> 30) / 64'd72);
        t = one_minus(((x2 * t) >> 30) / 64'd42);
        t = one_minus(((x2 * t) >> 30) / 64'd20);
        t = one_minus(((x2 * t) >> 30) / 64'd6);
        v = (x * t) >> 30;
      end else begin
        t = one_minus(((x2 * t) >> 30) / 64'd132);
        t = one_minus(((x2 * t) >> 30) / 64'd90);
        t = one_minus(((x2 * t) >> 30) / 64'd56);
        t = one_minus(((x2 * t) >> 30) / 64'd30);
        t = one_minus(((x2 * t) >> 30) / 64'd12);
        t = one_minus(((x2 * t) >> 30) / 64'd2);
        v = t;
      end
      lut[r] = 16'((v + (64'd1 << 15)) >> 16);
    end
    return lut;
  endfunction

  localparam lut_t SIN_LUT = build_lut(1'b0);
  localparam lut_t COS_LUT = build_lut(1'b1);

  function automatic dir_t sat_dir(input wres_t v);
    if (v > wres_t'(DIR_ONE)) return DIR_ONE;
    if (v < -wres_t'(DIR_ONE)) return -DIR_ONE;
    return dir_t'(v[15:0]);
  endfunction

  function automatic pos_t sat32(input wres_t v);
    if (v > wres_t'(32'sh7fffffff)) return 32'sh7fffffff;
    if (v < -wres_t'(32'sh80000000) - wres_t'(0)) begin
      if (v < wres_t'(32'sh80000000)) return 32'sh80000000;
    end
    return pos_t'(v[31:0]);
  endfunction

endpackage

FILE: rtl/core/cpv_sincos.sv
// Sine/cosine unit: quantizes a Q3.13 angle to a table phase with a
// reciprocal multiplication, then reads the quarter-wave tables. Uses cpv_pkg.
module cpv_sincos import cpv_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  sc_req_t req_i,
  output sc_rsp_t rsp_o
);

  localparam int unsigned NUM_W     = SINE_TABLE_BITS + 17;
  // floor(n / 2pi) is exact for n < 2^NUM_W with this shift
  localparam int unsigned RCP_SHIFT = NUM_W + 16;
  localparam int unsigned RCP_W     = RCP_SHIFT - 15;
  localparam logic [63:0] RCP       = ((64'd1 << RCP_SHIFT) + 64'(TWO_PI_Q13) - 64'd1)
                                      / 64'(TWO_PI_Q13);

  sc_state_e state_q, state_d;
  logic [NUM_W-1:0]           num_q;
  logic [SINE_TABLE_BITS-1:0] quo_q;
  logic                       done_q;
  dir_t                       sin_q, cos_q;

  logic [NUM_W-1:0]       num;
  logic [NUM_W+RCP_W-1:0] prod;
  logic [SC_RBITS-1:0]    r;
  dir_t                   s_tab, c_tab, sin_d, cos_d;

  // angle * 2^B + pi, offset by 2^B full turns so the dividend stays positive
  assign num = (NUM_W'(req_i.angle) << SINE_TABLE_BITS) + NUM_W'(PI_Q13)
             + (NUM_W'(TWO_PI_Q13) << SINE_TABLE_BITS);

  assign prod = num_q * RCP_W'(RCP);

  always_comb begin
    state_d = state_q;
    case (state_q)
      SC_IDLE: if (req_i.start) state_d = SC_MUL;
      SC_MUL:  state_d = SC_LOOK;
      SC_LOOK: state_d = SC_IDLE;
      default: state_d = SC_IDLE;
    endcase
  end

  always_comb begin
    r     = quo_q[SC_RBITS-1:0];
    s_tab = dir_t'(SIN_LUT[r]);
    c_tab = dir_t'(COS_LUT[r]);
    case (quo_q[SINE_TABLE_BITS-1 -: 2])
      2'd0:    begin sin_d = s_tab;  cos_d = c_tab;  end
      2'd1:    begin sin_d = c_tab;  cos_d = -s_tab; end
      2'd2:    begin sin_d = -s_tab; cos_d = -c_tab; end
      default: begin sin_d = -c_tab; cos_d = s_tab;  end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SC_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == SC_LOOK);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == SC_IDLE && req_i.start) begin
      num_q <= num;
    end
    // quotient modulo the table size is the phase index
    if (state_q == SC_MUL) begin
      quo_q <= prod[RCP_SHIFT +: SINE_TABLE_BITS];
    end
    if (state_q == SC_LOOK) begin
      sin_q <= sin_d;
      cos_q <= cos_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.sin  = sin_q;
  assign rsp_o.cos  = cos_q;

endmodule

FILE: rtl/core/cpv_mac.sv
// Shared multiply-accumulate unit: up to three signed 16x32 terms per job,
// product registered, result rounded to Q14. Uses cpv_pkg.
module cpv_mac import cpv_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mac_req_t req_i,
  output mac_rsp_t rsp_o
);

  logic                    issue_q, pvld_q, plast_q, pneg_q, done_q;
  logic [1:0]              idx_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q, acc_rnd;
  logic                    is_last;

  assign is_last = (idx_q == req_i.nterms - 2'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_q <= 1'b0;
      idx_q   <= '0;
      pvld_q  <= 1'b0;
      plast_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      done_q  <= pvld_q & plast_q;
      pvld_q  <= issue_q;
      plast_q <= issue_q & is_last;
      if (req_i.start) begin
        issue_q <= 1'b1;
        idx_q   <= '0;
      end else if (issue_q) begin
        idx_q <= idx_q + 2'd1;
        if (is_last) issue_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue_q) begin
      prod_q <= req_i.a * req_i.b;
      pneg_q <= req_i.neg;
    end
    if (req_i.start) begin
      acc_q <= '0;
    end else if (pvld_q) begin
      acc_q <= pneg_q ? acc_q - ACC_W'(prod_q) : acc_q + ACC_W'(prod_q);
    end
  end

  assign acc_rnd     = acc_q + ACC_W'(8192);
  assign rsp_o.done   = done_q;
  assign rsp_o.term   = idx_q;
  assign rsp_o.result = res_t'(acc_rnd[ACC_W-1:14]);

endmodule

FILE: rtl/core/camera_pose_view_matrix.sv
// First-person camera pose keeper with view-matrix row output: top level
// with the command sequencer. Uses cpv_pkg, cpv_sincos and cpv_mac.
//
// Usage: a command (req_type, turn_angle, move_distance) is a request on the
// in_ channel (valid/ready). Each command turns, moves or resets the pose and
// then yields three requests on the out_ channel: rows right, up and negated
// forward, each with its translation offset; last_row marks the third.
// Start position registers are written on the cfg_ channel (index 0..2 =
// x, y, z; other indexes are ignored); cfg_ready_o is always high.
// The three rows follow the pose update one after another. Their pace is
// set by the single 16x32 multiply-accumulate unit, which computes every
// product in turn, and by the sin/cos unit (per angle: register,
// reciprocal multiply for the phase, table read). One command is
// in work at a time; in_ready_o is high only in idle. Rows sit in an output
// register; while the receiver stalls the sequencer holds the next row and
// the block waits. After the third row is loaded the next command is
// accepted even if that row is still not taken.
// Reset puts the camera at the origin looking down -z with yaw = pitch = 0
// and clears the start registers.
module camera_pose_view_matrix import cpv_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         req_type_i,
  input  logic signed [15:0] turn_angle_i,
  input  logic signed [31:0] move_distance_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         row_index_o,
  output logic signed [15:0] col_x_o,
  output logic signed [15:0] col_y_o,
  output logic signed [15:0] col_z_o,
  output logic signed [31:0] offset_o,
  output logic               last_row_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  cpv_state_e state_q, state_d;
  cpv_job_e   job_q, job_d;

  logic [2:0]         cmd_q;
  logic signed [15:0] ang_q, yaw_q, pitch_q;
  pos_t               dist_q;
  pos_t               start_q [3];
  pos_t               pos_q [3];
  dir_t               fwd_q [3];
  dir_t               right_q [3];
  dir_t               up_q [3];
  dir_t               sin_q, cos_q, cp_q;
  pos_t               off_q;

  logic               out_valid_q, last_q;
  logic [1:0]         row_q;
  dir_t               cx_q, cy_q, cz_q;
  pos_t               ofs_out_q;

  sc_req_t  sc_req;
  sc_rsp_t  sc_rsp;
  mac_req_t mac_req;
  mac_rsp_t mac_rsp;

  logic               accept, out_free, push;
  logic signed [16:0] yaw_sum, yaw_nx, pitch_sum;
  logic signed [15:0] pitch_nx;
  dir_t               mv_dir [3];
  logic [1:0]         mv_idx;
  wres_t              res_w;

  cpv_sincos u_sincos (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (sc_req),
    .rsp_o  (sc_rsp)
  );

  cpv_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mac_req),
    .rsp_o  (mac_rsp)
  );

  function automatic dir_t pick_dir(input dir_t v [3], input logic [1:0] i);
    case (i)
      2'd0:    return v[0];
      2'd1:    return v[1];
      default: return v[2];
    endcase
  endfunction

  function automatic pos_t pick_pos(input pos_t v [3], input logic [1:0] i);
    case (i)
      2'd0:    return v[0];
      2'd1:    return v[1];
      default: return v[2];
    endcase
  endfunction

  function automatic cpv_job_e next_job(input cpv_job_e j);
    case (j)
      JOB_FWD_X:  return JOB_FWD_Z;
      JOB_UP_X:   return JOB_UP_Y;
      JOB_UP_Y:   return JOB_UP_Z;
      JOB_MOVE_X: return JOB_MOVE_Y;
      JOB_MOVE_Y: return JOB_MOVE_Z;
      JOB_DOT_R:  return JOB_DOT_U;
      JOB_DOT_U:  return JOB_DOT_F;
      default:    return JOB_DOT_R;
    endcase
  endfunction

  assign out_free = !out_valid_q || out_ready_i;
  assign accept   = in_valid_i && in_ready_o;
  assign res_w    = wres_t'(mac_rsp.result);

  // angle updates: yaw wraps into [-pi, pi), pitch clamps to +-1.5 rad
  always_comb begin
    yaw_sum = 17'(yaw_q) + 17'(ang_q);
    if (yaw_sum >= $signed({1'b0, PI_Q13})) begin
      yaw_nx = yaw_sum - $signed(TWO_PI_Q13);
    end else if (yaw_sum < -$signed({1'b0, PI_Q13})) begin
      yaw_nx = yaw_sum + $signed(TWO_PI_Q13);
    end else begin
      yaw_nx = yaw_sum;
    end
    pitch_sum = 17'(pitch_q) + 17'(ang_q);
    if (pitch_sum > 17'(PITCH_MAX)) begin
      pitch_nx = PITCH_MAX;
    end else if (pitch_sum < -17'(PITCH_MAX)) begin
      pitch_nx = -PITCH_MAX;
    end else begin
      pitch_nx = pitch_sum[15:0];
    end
  end

  // next state and job
  always_comb begin
    state_d = state_q;
    job_d   = job_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (req_type_e'(req_type_i))
            REQ_YAW, REQ_PITCH: state_d = ST_ANGLE;
            REQ_FWD, REQ_RIGHT, REQ_UP: begin
              state_d = ST_MAC_GO;
              job_d   = JOB_MOVE_X;
            end
            default: begin
              state_d = ST_MAC_GO;
              job_d   = JOB_DOT_R;
            end
          endcase
        end
      end
      ST_ANGLE:    state_d = (cmd_q == REQ_PITCH) ? ST_SCP_GO : ST_SCY_GO;
      ST_SCP_GO:   state_d = ST_SCP_WAIT;
      ST_SCP_WAIT: if (sc_rsp.done) state_d = ST_SCY_GO;
      ST_SCY_GO:   state_d = ST_SCY_WAIT;
      ST_SCY_WAIT: begin
        if (sc_rsp.done) begin
          if (cmd_q == REQ_PITCH) begin
            state_d = ST_MAC_GO;
            job_d   = JOB_FWD_X;
          end else begin
            state_d = ST_FRAME;
          end
        end
      end
      ST_FRAME: begin
        state_d = ST_MAC_GO;
        job_d   = JOB_UP_X;
      end
      ST_MAC_GO: state_d = ST_MAC_WAIT;
      ST_MAC_WAIT: begin
        if (mac_rsp.done) begin
          case (job_q)
            JOB_DOT_R, JOB_DOT_U, JOB_DOT_F: state_d = ST_PUSH;
            JOB_FWD_Z: state_d = ST_FRAME;
            default: begin
              state_d = ST_MAC_GO;
              job_d   = next_job(job_q);
            end
          endcase
        end
      end
      ST_PUSH: begin
        if (out_free) begin
          if (job_q == JOB_DOT_F) begin
            state_d = ST_IDLE;
          end else begin
            state_d = ST_MAC_GO;
            job_d   = next_job(job_q);
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs: handshakes and shared-unit operands
  always_comb begin
    in_ready_o   = (state_q == ST_IDLE);
    push         = (state_q == ST_PUSH) && out_free;
    sc_req.start = (state_q == ST_SCP_GO) || (state_q == ST_SCY_GO);
    sc_req.angle = (state_q == ST_SCP_GO) ? pitch_q : yaw_q;

    case (cmd_q)
      REQ_FWD:   mv_dir = fwd_q;
      REQ_RIGHT: mv_dir = right_q;
      default:   mv_dir = up_q;
    endcase
    case (job_q)
      JOB_MOVE_X: mv_idx = 2'd0;
      JOB_MOVE_Y: mv_idx = 2'd1;
      default:    mv_idx = 2'd2;
    endcase

    mac_req.start  = (state_q == ST_MAC_GO);
    mac_req.nterms = 2'd1;
    mac_req.neg    = 1'b0;
    mac_req.a      = '0;
    mac_req.b      = '0;
    case (job_q)
      JOB_FWD_X: begin
        mac_req.a = -sin_q;
        mac_req.b = pos_t'(cp_q);
      end
      JOB_FWD_Z: begin
        mac_req.a = -cos_q;
        mac_req.b = pos_t'(cp_q);
      end
      // up = right x forward with right = (-fz, 0, fx)
      JOB_UP_X: begin
        mac_req.a   = fwd_q[0];
        mac_req.b   = pos_t'(fwd_q[1]);
        mac_req.neg = 1'b1;
      end
      JOB_UP_Y: begin
        mac_req.nterms = 2'd2;
        if (mac_rsp.term == 2'd0) begin
          mac_req.a = fwd_q[0];
          mac_req.b = pos_t'(fwd_q[0]);
        end else begin
          mac_req.a   = right_q[0];
          mac_req.b   = pos_t'(fwd_q[2]);
          mac_req.neg = 1'b1;
        end
      end
      JOB_UP_Z: begin
        mac_req.a = right_q[0];
        mac_req.b = pos_t'(fwd_q[1]);
      end
      JOB_MOVE_X, JOB_MOVE_Y, JOB_MOVE_Z: begin
        mac_req.a = pick_dir(mv_dir, mv_idx);
        mac_req.b = dist_q;
      end
      JOB_DOT_R: begin
        mac_req.nterms = 2'd3;
        mac_req.a      = pick_dir(right_q, mac_rsp.term);
        mac_req.b      = pick_pos(pos_q, mac_rsp.term);
      end
      JOB_DOT_U: begin
        mac_req.nterms = 2'd3;
        mac_req.a      = pick_dir(up_q, mac_rsp.term);
        mac_req.b      = pick_pos(pos_q, mac_rsp.term);
      end
      default: begin
        mac_req.nterms = 2'd3;
        mac_req.a      = pick_dir(fwd_q, mac_rsp.term);
        mac_req.b      = pick_pos(pos_q, mac_rsp.term);
      end
    endcase
  end

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      job_q       <= JOB_DOT_R;
      cmd_q       <= '0;
      yaw_q       <= '0;
      pitch_q     <= '0;
      start_q     <= '{default: '0};
      pos_q       <= '{default: '0};
      fwd_q       <= '{16'sd0, 16'sd0, -DIR_ONE};
      right_q     <= '{DIR_ONE, 16'sd0, 16'sd0};
      up_q        <= '{16'sd0, DIR_ONE, 16'sd0};
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      job_q   <= job_d;

      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_START_X: start_q[0] <= cfg_data_i;
          CFG_START_Y: start_q[1] <= cfg_data_i;
          CFG_START_Z: start_q[2] <= cfg_data_i;
          default: ;
        endcase
      end

      if (accept) begin
        cmd_q <= req_type_i;
        if (req_type_i == REQ_RESET) begin
          pos_q   <= start_q;
          yaw_q   <= '0;
          pitch_q <= '0;
          fwd_q   <= '{16'sd0, 16'sd0, -DIR_ONE};
          right_q <= '{DIR_ONE, 16'sd0, 16'sd0};
          up_q    <= '{16'sd0, DIR_ONE, 16'sd0};
        end
      end

      if (state_q == ST_ANGLE) begin
        if (cmd_q == REQ_PITCH) pitch_q <= pitch_nx;
        else yaw_q <= yaw_nx[15:0];
      end

      if (state_q == ST_SCP_WAIT && sc_rsp.done) begin
        fwd_q[1] <= sc_rsp.sin;
      end

      // a yaw turn builds a level forward vector
      if (state_q == ST_SCY_WAIT && sc_rsp.done && cmd_q != REQ_PITCH) begin
        fwd_q[0] <= -sc_rsp.sin;
        fwd_q[1] <= '0;
        fwd_q[2] <= -sc_rsp.cos;
      end

      if (state_q == ST_FRAME) begin
        right_q[0] <= sat_dir(-wres_t'(fwd_q[2]));
        right_q[1] <= '0;
        right_q[2] <= fwd_q[0];
      end

      if (state_q == ST_MAC_WAIT && mac_rsp.done) begin
        case (job_q)
          JOB_FWD_X:  fwd_q[0] <= sat_dir(res_w);
          JOB_FWD_Z:  fwd_q[2] <= sat_dir(res_w);
          JOB_UP_X:   up_q[0]  <= sat_dir(res_w);
          JOB_UP_Y:   up_q[1]  <= sat_dir(res_w);
          JOB_UP_Z:   up_q[2]  <= sat_dir(res_w);
          JOB_MOVE_X: pos_q[0] <= sat32(wres_t'(pos_q[0]) + res_w);
          JOB_MOVE_Y: pos_q[1] <= sat32(wres_t'(pos_q[1]) + res_w);
          JOB_MOVE_Z: pos_q[2] <= sat32(wres_t'(pos_q[2]) + res_w);
          default: ;
        endcase
      end

      if (push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ang_q  <= turn_angle_i;
      dist_q <= move_distance_i;
    end
    if (state_q == ST_SCP_WAIT && sc_rsp.done) begin
      cp_q <= sc_rsp.cos;
    end
    if (state_q == ST_SCY_WAIT && sc_rsp.done) begin
      sin_q <= sc_rsp.sin;
      cos_q <= sc_rsp.cos;
    end
    if (state_q == ST_MAC_WAIT && mac_rsp.done) begin
      off_q <= (job_q == JOB_DOT_F) ? sat32(res_w) : sat32(-res_w);
    end
    if (push) begin
      ofs_out_q <= off_q;
      case (job_q)
        JOB_DOT_R: begin
          row_q  <= ROW_RIGHT;
          cx_q   <= right_q[0];
          cy_q   <= right_q[1];
          cz_q   <= right_q[2];
          last_q <= 1'b0;
        end
        JOB_DOT_U: begin
          row_q  <= ROW_UP;
          cx_q   <= up_q[0];
          cy_q   <= up_q[1];
          cz_q   <= up_q[2];
          last_q <= 1'b0;
        end
        default: begin
          row_q  <= ROW_FWD;
          cx_q   <= -fwd_q[0];
          cy_q   <= -fwd_q[1];
          cz_q   <= -fwd_q[2];
          last_q <= 1'b1;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign row_index_o = row_q;
  assign col_x_o     = cx_q;
  assign col_y_o     = cy_q;
  assign col_z_o     = cz_q;
  assign offset_o    = ofs_out_q;
  assign last_row_o  = last_q;

endmodule

FILE: tb/sv/cpv_view_checker.sv
// Watches the camera pose block's command, row and start-register channels,
// tracks the expected pose and compares every view-matrix row.
// Uses cpv_pkg for the command codes and register indexes.
module cpv_view_checker import cpv_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [2:0]         req_type_i,
  input  logic signed [15:0] turn_angle_i,
  input  logic signed [31:0] move_distance_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [1:0]         row_index_i,
  input  logic signed [15:0] col_x_i,
  input  logic signed [15:0] col_y_i,
  input  logic signed [15:0] col_z_i,
  input  logic signed [31:0] offset_i,
  input  logic               last_row_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  output int                 fail_count_o,
  output int                 rows_pending_o
);

  typedef struct packed {
    logic [1:0]         idx;
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic signed [15:0] cz;
    logic signed [31:0] offs;
    logic               last;
  } view_row_t;

  view_row_t row_q[$];
  longint start_pos[3];
  longint pos[3];
  longint fwd[3];
  longint rgt[3];
  longint upv[3];
  longint yaw;
  longint pitch;

  assign rows_pending_o = row_q.size();

  function automatic longint floor_sh(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint rnd_sh(longint v, int n);
    return floor_sh(v + (64'sd1 << (n - 1)), n);
  endfunction

  function automatic longint clamp_dir(longint v);
    if (v > 16384) return 16384;
    if (v < -16384) return -16384;
    return v;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint quad_poly(longint r, bit want_cos);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned sub;
    longint unsigned v;
    longint unsigned sdiv[5];
    longint unsigned cdiv[6];
    sdiv = '{110, 72, 42, 20, 6};
    cdiv = '{132, 90, 56, 30, 12, 2};
    x = longint'(r) * 64'd1686629713 / 256;
    x2 = (x * x) >> 30;
    t = 64'd1 << 30;
    if (!want_cos) begin
      for (int i = 0; i < 5; i++) begin
        sub = ((x2 * t) >> 30) / sdiv[i];
        t = (sub > (64'd1 << 30)) ? 0 : (64'd1 << 30) - sub;
      end
      v = (x * t) >> 30;
    end else begin
      for (int i = 0; i < 6; i++) begin
        sub = ((x2 * t) >> 30) / cdiv[i];
        t = (sub > (64'd1 << 30)) ? 0 : (64'd1 << 30) - sub;
      end
      v = t;
    end
    return longint'((v + (64'd1 << 15)) >> 16);
  endfunction

  task automatic phase_sin_cos(input longint a, output longint sn, output longint cs);
    longint num;
    longint q;
    longint idx;
    longint s14;
    longint c14;
    num = a * 1024 + 25736;
    q = num / 51472;
    if ((num % 51472) != 0 && num < 0) q--;
    idx = q & 1023;
    s14 = quad_poly(idx & 255, 1'b0);
    c14 = quad_poly(idx & 255, 1'b1);
    case (idx >> 8)
      0: begin sn = s14; cs = c14; end
      1: begin sn = c14; cs = -s14; end
      2: begin sn = -s14; cs = -c14; end
      default: begin sn = -c14; cs = s14; end
    endcase
  endtask

  task automatic level_frame();
    rgt[0] = clamp_dir(-fwd[2]);
    rgt[1] = 0;
    rgt[2] = fwd[0];
    upv[0] = clamp_dir(rnd_sh(rgt[1] * fwd[2] - rgt[2] * fwd[1], 14));
    upv[1] = clamp_dir(rnd_sh(rgt[2] * fwd[0] - rgt[0] * fwd[2], 14));
    upv[2] = clamp_dir(rnd_sh(rgt[0] * fwd[1] - rgt[1] * fwd[0], 14));
  endtask

  task automatic home_dirs();
    fwd = '{0, 0, -16384};
    rgt = '{16384, 0, 0};
    upv = '{0, 16384, 0};
  endtask

  function automatic longint dot_pos(longint d[3]);
    return rnd_sh(d[0] * pos[0] + d[1] * pos[1] + d[2] * pos[2], 14);
  endfunction

  task automatic move_pose(longint d[3], longint amount);
    for (int i = 0; i < 3; i++) pos[i] = clamp32(pos[i] + rnd_sh(d[i] * amount, 14));
  endtask

  task automatic apply_command(input logic [2:0] op, input longint ang, input longint dist_in);
    longint sy, cy, sp, cp;
    view_row_t r;
    case (op)
      REQ_YAW: begin
        yaw = yaw + ang;
        while (yaw >= 25736) yaw -= 51472;
        while (yaw < -25736) yaw += 51472;
        phase_sin_cos(yaw, sy, cy);
        fwd = '{-sy, 0, -cy};
        level_frame();
      end
      REQ_PITCH: begin
        pitch = pitch + ang;
        if (pitch > 12288) pitch = 12288;
        if (pitch < -12288) pitch = -12288;
        phase_sin_cos(pitch, sp, cp);
        phase_sin_cos(yaw, sy, cy);
        fwd[0] = clamp_dir(rnd_sh(-sy * cp, 14));
        fwd[1] = sp;
        fwd[2] = clamp_dir(rnd_sh(-cy * cp, 14));
        level_frame();
      end
      REQ_FWD: move_pose(fwd, dist_in);
      REQ_RIGHT: move_pose(rgt, dist_in);
      REQ_UP: move_pose(upv, dist_in);
      REQ_RESET: begin
        pos = start_pos;
        yaw = 0;
        pitch = 0;
        home_dirs();
      end
      default: ;
    endcase
    r = '{ROW_RIGHT, rgt[0], rgt[1], rgt[2], clamp32(-dot_pos(rgt)), 1'b0};
    row_q.push_back(r);
    r = '{ROW_UP, upv[0], upv[1], upv[2], clamp32(-dot_pos(upv)), 1'b0};
    row_q.push_back(r);
    r = '{ROW_FWD, -fwd[0], -fwd[1], -fwd[2], clamp32(dot_pos(fwd)), 1'b1};
    row_q.push_back(r);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    view_row_t e;
    if (!rst_ni) begin
      start_pos = '{0, 0, 0};
      pos = '{0, 0, 0};
      home_dirs();
      yaw = 0;
      pitch = 0;
      row_q.delete();
      fail_count_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (row_q.size() == 0) begin
          $display("%0t: unexpected row %0d", $time, row_index_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = row_q.pop_front();
          if (e != {row_index_i, col_x_i, col_y_i, col_z_i, offset_i, last_row_i}) begin
            $display("%0t: row mismatch exp idx=%0d x=%0d y=%0d z=%0d off=%0d last=%0d",
                     $time, e.idx, e.cx, e.cy, e.cz, e.offs, e.last);
            $display("%0t:              got idx=%0d x=%0d y=%0d z=%0d off=%0d last=%0d",
                     $time, row_index_i, col_x_i, col_y_i, col_z_i, offset_i, last_row_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i && cfg_index_i <= CFG_START_Z)
        start_pos[cfg_index_i] = longint'($signed(cfg_data_i));
      if (in_valid_i && in_ready_i)
        apply_command(req_type_i, turn_angle_i, move_distance_i);
    end
  end

endmodule

FILE: tb/sv/tb_camera_pose_view_matrix.sv
// Testbench top for camera_pose_view_matrix: directed and random commands,
// start-register phases, bursty sender, stalling receiver; uses cpv_view_checker.
module tb_camera_pose_view_matrix;
  import cpv_pkg::*;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [2:0]         req_type_i;
  logic signed [15:0] turn_angle_i;
  logic signed [31:0] move_distance_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [1:0]         row_index_o;
  logic signed [15:0] col_x_o;
  logic signed [15:0] col_y_o;
  logic signed [15:0] col_z_o;
  logic signed [31:0] offset_o;
  logic               last_row_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [1:0]         cfg_index_i;
  logic [31:0]        cfg_data_i;
  int                 fail_count;
  int                 rows_pending;
  int                 cycle_count;
  int                 stall_mode;

  camera_pose_view_matrix DUT (.*);

  cpv_view_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .req_type_i, .turn_angle_i,
    .move_distance_i, .out_valid_i(out_valid_o), .out_ready_i, .row_index_i(row_index_o),
    .col_x_i(col_x_o), .col_y_i(col_y_o), .col_z_i(col_z_o), .offset_i(offset_o),
    .last_row_i(last_row_o), .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i,
    .cfg_data_i, .fail_count_o(fail_count), .rows_pending_o(rows_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // run limit: ~110 commands plus receiver stalls stay far below this
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("FAIL camera_pose_view_matrix");
      $finish;
    end
  end

  // receiver stall pattern, switching mode now and then
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_mode <= 0;
    end else begin
      if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= ($urandom_range(0, 3) != 0);
        default: out_ready_i <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // valid stays up after the request; the caller drops it before any gap
  task automatic send_cmd(input logic [2:0] op, input logic [15:0] ang,
                          input logic [31:0] distance);
    in_valid_i <= 1'b1;
    req_type_i <= op;
    turn_angle_i <= ang;
    move_distance_i <= distance;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic write_start(input logic [1:0] idx, input logic [31:0] val);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (rows_pending != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_cmds(input int count);
    logic [2:0] op;
    int burst;
    int gap;
    burst = 0;
    for (int i = 0; i < count; i++) begin
      if (burst == 0) begin
        gap = $urandom_range(0, 6);
        if (gap != 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        burst = $urandom_range(1, 8);
      end
      burst--;
      op = ($urandom_range(0, 30) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
      case ($urandom_range(0, 3))
        0: send_cmd(op, $urandom, $urandom);
        1: send_cmd(op, 16'($signed($urandom_range(0, 8000)) - 4000),
                    32'($signed($urandom_range(0, 1 << 22)) - (1 << 21)));
        default: send_cmd(op, 16'($signed($urandom_range(0, 1600)) - 800),
                          32'($signed($urandom_range(0, 1 << 18)) - (1 << 17)));
      endcase
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    req_type_i = REQ_YAW;
    turn_angle_i = '0;
    move_distance_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_START_X;
    cfg_data_i = '0;
    cycle_count = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: every command, field extremes, yaw wrap, pitch clamp, unknown codes
    send_cmd(REQ_RESET, 0, 0);
    send_cmd(REQ_FWD, 0, 32'sh0001_0000);
    send_cmd(REQ_RIGHT, 0, 32'sh7fff_ffff);
    send_cmd(REQ_UP, 0, 32'sh8000_0000);
    send_cmd(REQ_FWD, 0, 32'sh7fff_ffff);
    send_cmd(REQ_YAW, 16'sh7fff, 0);
    send_cmd(REQ_YAW, 16'sh8000, 0);
    send_cmd(REQ_YAW, 16'sd25736, 0);
    send_cmd(REQ_YAW, -16'sd12868, 0);
    send_cmd(REQ_PITCH, 16'sh7fff, 0);
    send_cmd(REQ_PITCH, 16'sh8000, 0);
    send_cmd(REQ_PITCH, 16'sd4000, 0);
    send_cmd(REQ_RIGHT, 0, 32'sh8000_0000);
    send_cmd(REQ_UP, 16'hffff, 32'hffff_ffff);
    send_cmd(3'd6, 16'h5555, 32'haaaa_aaaa);
    send_cmd(3'd7, 16'haaaa, 32'h5555_5555);
    write_start(CFG_START_X, 32'h7fff_ffff);
    write_start(CFG_START_Y, 32'h8000_0000);
    write_start(CFG_START_Z, 32'h7fff_ffff);
    send_cmd(REQ_RESET, 0, 0);
    send_cmd(REQ_PITCH, 16'sd6000, 0);
    send_cmd(REQ_FWD, 0, 32'sh7fff_ffff);

    for (int phase = 0; phase < 3; phase++) begin
      write_start(CFG_START_X, (phase == 2) ? 32'h0 : $urandom);
      write_start(CFG_START_Y, $urandom_range(0, 1 << 24));
      write_start(CFG_START_Z, (phase == 1) ? 32'h8000_0000 : $urandom);
      random_cmds(30);
    end
    in_valid_i <= 1'b0;
    @(posedge clk_i);

    while (rows_pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (fail_count == 0) $display("PASS camera_pose_view_matrix");
    else $display("FAIL camera_pose_view_matrix");
    $finish;
  end

endmodule
